// File: rtl/hfr_pkg.sv
// Package for the HDLC frame receiver: result record, status codes and constants.
// Used by every module of the receiver; depends on nothing.
package hfr_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;
  localparam int unsigned QUEUE_DEPTH         = 4;

  localparam logic [7:0]  FLAG_BYTE    = 8'h7E;
  localparam logic [15:0] CRC_POLY     = 16'h8408;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_GOOD     = 16'hF0B8;
  localparam logic [7:0]  CTRL_BYTE    = 8'h03;
  localparam logic [7:0]  PROTO_BYTE   = 8'hCC;
  localparam int unsigned MIN_FRAME    = 6;
  localparam int unsigned ADDR_FRAME   = 24;

  typedef enum logic [3:0] {
    ST_ABORT      = 4'd0,
    ST_NONALIGNED = 4'd1,
    ST_RUNT       = 4'd2,
    ST_GIANT      = 4'd3,
    ST_CRC_ERR    = 4'd4,
    ST_OTHER_CH   = 4'd5,
    ST_NOT_IP     = 4'd6,
    ST_IP         = 4'd7,
    ST_READ       = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_IDLE    = 3'b010,
    PH_FRAMING = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ABORT = 2'd1,
    EV_CLOSE = 2'd2,
    EV_READ  = 2'd3
  } event_e;

  typedef struct packed {
    status_e     status;
    logic [11:0] frame_len;
    logic [9:0]  channel_found;
    logic [15:0] packet_len;
    logic [31:0] target_addr;
    logic [7:0]  read_byte;
  } result_t;

endpackage

// File: rtl/hdlc_frame_receiver_unit.sv
// HDLC frame receiver: one line bit or one store read per input transaction, a frame
// event or the read byte per output transaction. Needs hfr_pkg, hfr_front, hfr_queue.
//
// Takes one transaction per clock while in_stall_o is low. A line bit is processed in
// the cycle it is accepted; the frame event and the frame store read are registered
// ahead of the combinational classify stage. A four-entry result queue
// absorbs output stalls; input stall rises only when queue plus classify stage are full.
module hdlc_frame_receiver_unit import hfr_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic        line_bit_i,
  input  logic [10:0] read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [11:0] frame_len_o,
  output logic [9:0]  channel_found_o,
  output logic [15:0] packet_len_o,
  output logic [31:0] target_addr_o,
  output logic [7:0]  read_byte_o
);

  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  logic [9:0]    channel_q;
  logic          accept;
  logic          push;
  result_t       push_data;
  result_t       head;
  logic [NW-1:0] count;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (32'(count) + 32'(push)) >= QUEUE_DEPTH;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      channel_q <= cfg_data_i;
    end
  end

  hfr_front #(.MaxFrameBytes(MaxFrameBytes)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .channel_id_i (channel_q),
    .accept_i     (accept),
    .command_i    (command_i),
    .line_bit_i   (line_bit_i),
    .read_index_i (read_index_i),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  hfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (!out_stall_i),
    .valid_o     (out_valid_o),
    .data_o      (head),
    .count_o     (count)
  );

  assign status_o        = head.status;
  assign frame_len_o     = head.frame_len;
  assign channel_found_o = head.channel_found;
  assign packet_len_o    = head.packet_len;
  assign target_addr_o   = head.target_addr;
  assign read_byte_o     = head.read_byte;

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && command_i |=> push && push_data.status == ST_READ)
    else $error("read transaction produced no read result");

  a_bit_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !command_i |=> !(push && push_data.status == ST_READ))
    else $error("line bit produced a read result");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count) <= QUEUE_DEPTH && !(push && 32'(count) == QUEUE_DEPTH && out_stall_i))
    else $error("result queue overflow");

endmodule

// File: rtl/hfr_front.sv
// Front end of the HDLC frame receiver: flag hunt, destuffing, CRC, frame store
// and a classify stage that builds one result record. Depends on hfr_pkg.
module hfr_front import hfr_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [9:0]  channel_id_i,
  input  logic        accept_i,
  input  logic        command_i,
  input  logic        line_bit_i,
  input  logic [10:0] read_index_i,
  output logic        push_o,
  output result_t     push_data_o
);

  localparam int unsigned AW = $clog2(MaxFrameBytes);
  localparam int unsigned CW = $clog2(MaxFrameBytes + 2);

  logic [7:0] store_q [MaxFrameBytes];
  logic [7:0] rd_data_q;
  logic       rd_ok_q;

  phase_e      phase_q, phase_d;
  logic [7:0]  win_q, win_d;
  logic [2:0]  pc_q, pc_d;
  logic [3:0]  ones_q, ones_d;
  logic [2:0]  dr_q, dr_d;
  logic [7:0]  pb_q, pb_d;
  logic [2:0]  bib_q, bib_d;
  logic [CW-1:0] bc_q, bc_d;
  logic [15:0] crc_q, crc_d;
  event_e      ev_q, ev_d;

  logic [7:0]  h0_q, h1_q, h2_q, h3_q, h6_q, h7_q, h20_q, h21_q, h22_q, h23_q;

  logic        wr_en;
  logic [7:0]  wr_data;
  logic [7:0]  win_sh;
  logic        oldest;
  logic [7:0]  pb_n;
  logic [15:0] crc_n;

  assign win_sh  = {line_bit_i, win_q[7:1]};
  assign oldest  = win_q[0];
  assign pb_n    = {oldest, pb_q[7:1]};
  assign crc_n   = (crc_q >> 1) ^ (((crc_q[0] ^ oldest) == 1'b1) ? CRC_POLY : 16'h0000);
  assign wr_data = pb_n;

  always_comb begin
    phase_d = phase_q;
    win_d   = win_q;
    pc_d    = pc_q;
    ones_d  = ones_q;
    dr_d    = dr_q;
    pb_d    = pb_q;
    bib_d   = bib_q;
    bc_d    = bc_q;
    crc_d   = crc_q;
    ev_d    = EV_NONE;
    wr_en   = 1'b0;
    if (accept_i) begin
      if (command_i) begin
        ev_d = EV_READ;
      end else begin
        case (phase_q)
          PH_IDLE: begin
            if (win_sh == FLAG_BYTE) begin
              phase_d = PH_HUNT;
              win_d   = '0;
              pc_d    = '0;
            end else begin
              win_d   = win_sh;
              phase_d = PH_FRAMING;
              ones_d  = '0;
              dr_d    = '0;
              pb_d    = '0;
              bib_d   = '0;
              bc_d    = '0;
              crc_d   = CRC_INIT;
            end
          end
          PH_FRAMING: begin
            if (line_bit_i && ones_q == 4'd7) begin
              ones_d  = '0;
              phase_d = PH_HUNT;
              win_d   = '0;
              pc_d    = '0;
              ev_d    = EV_ABORT;
            end else begin
              ones_d = line_bit_i ? ones_q + 4'd1 : 4'd0;
              win_d  = win_sh;
              if (!(dr_q == 3'd5 && !oldest)) begin
                pb_d  = pb_n;
                crc_d = crc_n;
                bib_d = bib_q + 3'd1;
                if (bib_q == 3'd7) begin
                  wr_en = 32'(bc_q) < 32'(MaxFrameBytes);
                  if (32'(bc_q) <= 32'(MaxFrameBytes)) begin
                    bc_d = bc_q + CW'(1);
                  end
                end
              end
              if (oldest) begin
                dr_d = (dr_q < 3'd7) ? dr_q + 3'd1 : 3'd7;
              end else begin
                dr_d = '0;
              end
              if (win_sh == FLAG_BYTE) begin
                phase_d = PH_HUNT;
                win_d   = '0;
                pc_d    = '0;
                ev_d    = EV_CLOSE;
              end
            end
          end
          default: begin
            win_d = win_sh;
            if (pc_q == 3'd6) begin
              pc_d    = '0;
              phase_d = PH_IDLE;
            end else begin
              pc_d    = pc_q + 3'd1;
              phase_d = PH_HUNT;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      win_q   <= '0;
      pc_q    <= '0;
      ones_q  <= '0;
      dr_q    <= '0;
      pb_q    <= '0;
      bib_q   <= '0;
      bc_q    <= '0;
      crc_q   <= CRC_INIT;
      ev_q    <= EV_NONE;
    end else begin
      phase_q <= phase_d;
      win_q   <= win_d;
      pc_q    <= pc_d;
      ones_q  <= ones_d;
      dr_q    <= dr_d;
      pb_q    <= pb_d;
      bib_q   <= bib_d;
      bc_q    <= bc_d;
      crc_q   <= crc_d;
      ev_q    <= ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[AW'(bc_q)] <= wr_data;
      case (32'(bc_q))
        0:       h0_q  <= wr_data;
        1:       h1_q  <= wr_data;
        2:       h2_q  <= wr_data;
        3:       h3_q  <= wr_data;
        6:       h6_q  <= wr_data;
        7:       h7_q  <= wr_data;
        20:      h20_q <= wr_data;
        21:      h21_q <= wr_data;
        22:      h22_q <= wr_data;
        23:      h23_q <= wr_data;
        default: ;
      endcase
    end
    rd_data_q <= store_q[AW'(32'(read_index_i))];
    rd_ok_q   <= 32'(read_index_i) < 32'(MaxFrameBytes);
  end

  logic [9:0] ch;
  assign ch = {h0_q[7:2], h1_q[7:4]};

  always_comb begin
    push_o      = ev_q != EV_NONE;
    push_data_o = '0;
    case (ev_q)
      EV_READ: begin
        push_data_o.status    = ST_READ;
        push_data_o.read_byte = rd_ok_q ? rd_data_q : 8'h00;
      end
      EV_CLOSE: begin
        if (bib_q != 3'd0) begin
          push_data_o.status = ST_NONALIGNED;
        end else begin
          push_data_o.frame_len = 12'(bc_q);
          if (32'(bc_q) < MIN_FRAME) begin
            push_data_o.status = ST_RUNT;
          end else if (32'(bc_q) > 32'(MaxFrameBytes)) begin
            push_data_o.status = ST_GIANT;
          end else if (crc_q != CRC_GOOD) begin
            push_data_o.status = ST_CRC_ERR;
          end else begin
            if (ch != channel_id_i) begin
              push_data_o.status = ST_OTHER_CH;
            end else if (h2_q == CTRL_BYTE && h3_q == PROTO_BYTE) begin
              push_data_o.status = ST_IP;
            end else begin
              push_data_o.status = ST_NOT_IP;
            end
            push_data_o.channel_found = ch;
            if (32'(bc_q) >= ADDR_FRAME) begin
              push_data_o.packet_len  = {h6_q, h7_q};
              push_data_o.target_addr = {h20_q, h21_q, h22_q, h23_q};
            end
          end
        end
      end
      default: push_data_o.status = ST_ABORT;
    endcase
  end

endmodule

// File: rtl/hfr_queue.sv
// Result queue of the HDLC frame receiver; the head drives the output channel.
// Depends on hfr_pkg.
module hfr_queue import hfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  input  logic    pop_i,
  output logic    valid_o,
  output result_t data_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  result_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign pop     = pop_i && cnt_q != '0;
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];
  assign count_o = cnt_q;
  assign cnt_d   = cnt_q + NW'(push_i) - NW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (32'(wp_q) == QUEUE_DEPTH - 1) ? '0 : wp_q + PW'(1);
      end
      if (pop) begin
        rp_q <= (32'(rp_q) == QUEUE_DEPTH - 1) ? '0 : rp_q + PW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

endmodule

// File: verif/testbench.sv
// Self-checking bench for hdlc_frame_receiver_unit: directed frame table, then random traffic.
// Depends on hfr_pkg (status codes, result record) and the receiver RTL.
module testbench;
  import hfr_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned StoreBytes = MAX_FRAME_BYTES_DEF;
  localparam int unsigned RandItems  = 150;

  typedef enum {
    ROW_FRAME, ROW_BADFCS, ROW_ODD, ROW_ABORT, ROW_READ, ROW_BURST, ROW_CFG
  } row_op_e;

  typedef struct {
    row_op_e     op;
    int          len;
    int          chan;
    bit          ip;
    logic [10:0] idx;
    bit          chk;
    status_e     exp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [9:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = 1'b0;
  logic        line_bit_i = 1'b0;
  logic [10:0] read_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  status_o;
  logic [11:0] frame_len_o;
  logic [9:0]  channel_found_o;
  logic [15:0] packet_len_o;
  logic [31:0] target_addr_o;
  logic [7:0]  read_byte_o;

  hdlc_frame_receiver_unit u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .command_i, .line_bit_i, .read_index_i,
    .out_valid_o, .out_stall_i, .status_o, .frame_len_o, .channel_found_o,
    .packet_len_o, .target_addr_o, .read_byte_o
  );

  // receiver shadow state
  phase_e      rx_phase;
  logic [7:0]  rx_window;
  int          rx_preload;
  int          rx_ones;
  int          rx_destuff;
  logic [7:0]  rx_partial;
  int          rx_bits;
  int          rx_bytes;
  logic [15:0] rx_crc;
  logic [7:0]  rx_store [StoreBytes];
  int          rx_hiwater;
  logic [9:0]  rx_chan;

  result_t     expected_events[$];
  result_t     got_event;
  result_t     want_event;
  status_e     last_status;
  int          item_total;
  int          errors;
  int          cycles;
  int          stuff_ones;
  int          stall_left;
  bit          hold_on;
  event        long_hold_ev;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR t=%0t %s: got 0x%0h expected 0x%0h", $time, field, got, want);
    errors++;
  endtask

  task automatic hunt_restart();
    rx_phase   = PH_HUNT;
    rx_window  = '0;
    rx_preload = 0;
  endtask

  task automatic destuff(input logic b);
    if (rx_destuff != 5 || b) begin
      rx_partial = {b, rx_partial[7:1]};
      rx_crc = ((rx_crc[0] ^ b) != 1'b0) ? ((rx_crc >> 1) ^ CRC_POLY) : (rx_crc >> 1);
      rx_bits++;
      if (rx_bits == 8) begin
        rx_bits = 0;
        if (rx_bytes < StoreBytes) begin
          rx_store[rx_bytes] = rx_partial;
          if (rx_bytes >= rx_hiwater) rx_hiwater = rx_bytes + 1;
        end
        if (rx_bytes <= StoreBytes) rx_bytes++;
      end
    end
    rx_destuff = b ? ((rx_destuff < 7) ? rx_destuff + 1 : 7) : 0;
  endtask

  task automatic classify(output result_t r);
    logic [9:0] ch;
    r = '0;
    if (rx_bits != 0) begin
      r.status = ST_NONALIGNED;
      return;
    end
    r.frame_len = rx_bytes[11:0];
    if (rx_bytes < MIN_FRAME) r.status = ST_RUNT;
    else if (rx_bytes > StoreBytes) r.status = ST_GIANT;
    else if (rx_crc != CRC_GOOD) r.status = ST_CRC_ERR;
    else begin
      ch = {rx_store[0][7:2], rx_store[1][7:4]};
      if (ch != rx_chan) r.status = ST_OTHER_CH;
      else if (rx_store[2] == CTRL_BYTE && rx_store[3] == PROTO_BYTE) r.status = ST_IP;
      else r.status = ST_NOT_IP;
      r.channel_found = ch;
      if (rx_bytes >= ADDR_FRAME) begin
        r.packet_len  = {rx_store[6], rx_store[7]};
        r.target_addr = {rx_store[20], rx_store[21], rx_store[22], rx_store[23]};
      end
    end
  endtask

  task automatic rx_step(input logic cmd, input logic b, input logic [10:0] idx);
    result_t r;
    logic    hit;
    logic    oldest;
    r = '0;
    hit = 1'b0;
    if (cmd) begin
      r.status = ST_READ;
      r.read_byte = rx_store[idx];
      hit = 1'b1;
    end else if (rx_phase == PH_IDLE) begin
      rx_window = {b, rx_window[7:1]};
      if (rx_window == FLAG_BYTE) hunt_restart();
      else begin
        rx_phase   = PH_FRAMING;
        rx_ones    = 0;
        rx_destuff = 0;
        rx_partial = '0;
        rx_bits    = 0;
        rx_bytes   = 0;
        rx_crc     = CRC_INIT;
      end
    end else if (rx_phase == PH_FRAMING) begin
      rx_ones = b ? rx_ones + 1 : 0;
      if (rx_ones > 7) begin
        rx_ones = 0;
        hunt_restart();
        r.status = ST_ABORT;
        hit = 1'b1;
      end else begin
        oldest = rx_window[0];
        rx_window = {b, rx_window[7:1]};
        destuff(oldest);
        if (rx_window == FLAG_BYTE) begin
          classify(r);
          hunt_restart();
          hit = 1'b1;
        end
      end
    end else begin
      rx_window = {b, rx_window[7:1]};
      rx_preload++;
      if (rx_preload >= 7) begin
        rx_preload = 0;
        rx_phase = PH_IDLE;
      end
    end
    if (hit) begin
      expected_events.push_back(r);
      last_status = r.status;
    end
  endtask

  task automatic send_item(input logic cmd, input logic b, input logic [10:0] idx);
    int gap;
    if ($urandom_range(0, 7) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    line_bit_i   <= cmd ? 1'($urandom_range(0, 1)) : b;
    read_index_i <= cmd ? idx : 11'($urandom_range(0, 2047));
    do @(posedge clk_i); while (in_stall_o);
    item_total++;
    rx_step(cmd, b, idx);
  endtask

  task automatic send_flag();
    for (int i = 0; i < 8; i++) send_item(1'b0, FLAG_BYTE[i], '0);
    stuff_ones = 0;
  endtask

  task automatic send_stuffed(input logic b);
    send_item(1'b0, b, '0);
    stuff_ones = b ? stuff_ones + 1 : 0;
    if (stuff_ones == 5) begin
      send_item(1'b0, 1'b0, '0);
      stuff_ones = 0;
    end
  endtask

  task automatic send_frame(input int len, input int chan, input bit ip, input bit bad_fcs,
                            input int extra_bits);
    logic [7:0]  body[$];
    logic [15:0] crc;
    logic [7:0]  v;
    for (int i = 0; i < len; i++) body.push_back(8'($urandom));
    if (len >= 2) begin
      body[0][7:2] = chan[9:4];
      body[1][7:4] = chan[3:0];
    end
    if (ip && len >= 4) begin
      body[2] = CTRL_BYTE;
      body[3] = PROTO_BYTE;
    end
    crc = CRC_INIT;
    foreach (body[i]) begin
      v = body[i];
      for (int k = 0; k < 8; k++)
        crc = ((crc[0] ^ v[k]) != 1'b0) ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    crc = ~crc;
    if (bad_fcs) crc[$urandom_range(0, 15)] ^= 1'b1;
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    send_flag();
    foreach (body[i]) begin
      v = body[i];
      for (int k = 0; k < 8; k++) send_stuffed(v[k]);
    end
    for (int i = 0; i < extra_bits; i++) send_stuffed(1'($urandom_range(0, 1)));
    send_flag();
  endtask

  task automatic send_abort();
    send_flag();
    for (int i = 0; i < 24; i++) send_stuffed(1'($urandom_range(0, 1)));
    send_item(1'b0, 1'b0, '0);
    repeat (8) send_item(1'b0, 1'b1, '0);
    stuff_ones = 0;
  endtask

  task automatic write_channel(input logic [9:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (expected_events.size() == 0);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    rx_chan = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_on) out_stall_i <= 1'b1;
    else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else out_stall_i <= 1'b0;
  end

  initial begin
    forever begin
      @(long_hold_ev);
      hold_on = 1'b1;
      repeat (200) @(posedge clk_i);
      hold_on = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) report("unexpected transaction, status", status_o, 0);
      else begin
        want_event = expected_events.pop_front();
        got_event = {status_e'(status_o), frame_len_o, channel_found_o, packet_len_o,
                     target_addr_o, read_byte_o};
        if (got_event.status != want_event.status)
          report("status", got_event.status, want_event.status);
        if (got_event.frame_len != want_event.frame_len)
          report("frame_len", got_event.frame_len, want_event.frame_len);
        if (got_event.channel_found != want_event.channel_found)
          report("channel_found", got_event.channel_found, want_event.channel_found);
        if (got_event.packet_len != want_event.packet_len)
          report("packet_len", got_event.packet_len, want_event.packet_len);
        if (got_event.target_addr != want_event.target_addr)
          report("target_addr", got_event.target_addr, want_event.target_addr);
        if (got_event.read_byte != want_event.read_byte)
          report("read_byte", got_event.read_byte, want_event.read_byte);
      end
    end
  end

  row_t plan [18];

  initial begin
    int pick;
    int chan;
    int frames;
    int rand_start_items;
    plan = '{
      '{ROW_CFG,    0,    0,    0, 11'd0,    0, ST_READ},
      '{ROW_FRAME,  0,    0,    0, 11'd0,    1, ST_RUNT},
      '{ROW_FRAME,  3,    0,    1, 11'd0,    1, ST_RUNT},
      '{ROW_FRAME,  4,    0,    1, 11'd0,    1, ST_IP},
      '{ROW_FRAME,  22,   0,    1, 11'd0,    1, ST_IP},
      '{ROW_FRAME,  6,    5,    1, 11'd0,    1, ST_OTHER_CH},
      '{ROW_BADFCS, 6,    0,    1, 11'd0,    1, ST_CRC_ERR},
      '{ROW_ODD,    4,    0,    1, 11'd0,    1, ST_NONALIGNED},
      '{ROW_ABORT,  0,    0,    0, 11'd0,    1, ST_ABORT},
      '{ROW_READ,   0,    0,    0, 11'd0,    1, ST_READ},
      '{ROW_READ,   0,    0,    0, 11'd23,   1, ST_READ},
      '{ROW_READ,   0,    0,    0, 11'd10,   1, ST_READ},
      '{ROW_BURST,  0,    0,    0, 11'd0,    0, ST_READ},
      '{ROW_FRAME,  8,    0,    0, 11'd0,    0, ST_NOT_IP},
      '{ROW_CFG,    1023, 0,    0, 11'd0,    0, ST_READ},
      '{ROW_FRAME,  4,    1023, 1, 11'd0,    1, ST_IP},
      '{ROW_FRAME,  4,    0,    1, 11'd0,    1, ST_OTHER_CH},
      '{ROW_CFG,    0,    0,    0, 11'd0,    0, ST_READ}
    };
    rx_chan = '0;
    rx_hiwater = 0;
    hunt_restart();
    rx_ones = 0;
    rx_destuff = 0;
    rx_partial = '0;
    rx_bits = 0;
    rx_bytes = 0;
    rx_crc = CRC_INIT;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      last_status = ST_READ;
      case (plan[r].op)
        ROW_FRAME:  send_frame(plan[r].len, plan[r].chan, plan[r].ip, 0, 0);
        ROW_BADFCS: send_frame(plan[r].len, plan[r].chan, plan[r].ip, 1, 0);
        ROW_ODD:    send_frame(plan[r].len, plan[r].chan, plan[r].ip, 0, 3);
        ROW_ABORT:  send_abort();
        ROW_READ:   send_item(1'b1, 1'b0, plan[r].idx);
        ROW_BURST: begin
          ->long_hold_ev;
          repeat (12) send_item(1'b1, 1'b0, 11'($urandom_range(0, rx_hiwater - 1)));
        end
        ROW_CFG:    write_channel(10'(plan[r].len));
        default: ;
      endcase
      if (plan[r].chk && last_status != plan[r].exp)
        report("directed row status", last_status, plan[r].exp);
    end

    rand_start_items = item_total;
    frames = 0;
    while (item_total - rand_start_items < RandItems) begin
      pick = $urandom_range(0, 99);
      chan = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : rx_chan;
      if (pick < 60) send_frame($urandom_range(0, 10), chan, $urandom_range(0, 1), 0, 0);
      else if (pick < 68) send_frame($urandom_range(2, 10), chan, $urandom_range(0, 1), 1, 0);
      else if (pick < 75)
        send_frame($urandom_range(0, 8), chan, $urandom_range(0, 1), 0, $urandom_range(1, 7));
      else if (pick < 80) send_abort();
      else if (pick < 85) begin
        repeat ($urandom_range(1, 20)) send_item(1'b0, 1'($urandom_range(0, 1)), '0);
        stuff_ones = 0;
      end else
        repeat ($urandom_range(1, 4))
          send_item(1'b1, 1'b0, 11'($urandom_range(0, rx_hiwater - 1)));
      frames++;
      if (frames % 5 == 0) write_channel(10'($urandom_range(0, 1023)));
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (expected_events.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/hfr_pkg.sv
rtl/hfr_front.sv
rtl/hfr_queue.sv
rtl/hdlc_frame_receiver_unit.sv
verif/testbench.sv
